// File: design/triangle_edge_opacity_test_top_macros.svh
// Assertion macros used by the checker file of the edge opacity test.
`ifndef TRIANGLE_EDGE_OPACITY_TEST_TOP_MACROS_SVH
`define TRIANGLE_EDGE_OPACITY_TEST_TOP_MACROS_SVH

// Check cons in the cycle after ante, ignored while reset is low.
`define TEOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("teot check failed");

// Check cons in the cycle after ante, also through reset.
`define TEOT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("teot check failed");

`endif

// File: design/teot_pkg.sv
`default_nettype none

package teot_pkg;

  // Default largest image side; the alpha store holds its square.
  localparam int MAX_SIDE_DEF = 256;

  // Field widths
  localparam int PIX_W    = 16;
  localparam int ALPHA_W  = 8;
  localparam int VTX_W    = 10;
  localparam int CFG_W    = 9;
  localparam int REG_IDX_W = 2;

  // Internal widths: deltas, image sides up to 2047, walk coordinates
  localparam int DELTA_W  = 11;
  localparam int DIM_W    = 11;
  localparam int COORD_W  = 13;
  localparam int PROD_W   = 2 * DIM_W;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd2;

  // Edge codes
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

endpackage

`default_nettype wire

// File: design/triangle_edge_opacity_test_top.sv
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   in_command, in_pixel_index, in_pixel_alpha, vertices
// out      source     out_valid/out_stall out_keep_triangle
// cfg      sink       cfg_wr_en           cfg_index, cfg_data
//
// A write beat stores one in-range alpha pixel in the accepting cycle; the block stays ready.
// A test beat runs, per edge, a delta and a prep setup state, then a walk that takes one
// step of that edge's major delta at a time in the shared add/compare step unit; after
// the last edge a drain state empties the multiply, store read and threshold stages.
// rst_n is synchronous, active low; the alpha store is not cleared.
// in_stall is high while a test is in flight; a held result waits in the out register.
`default_nettype none

module triangle_edge_opacity_test_top #(
  parameter int MAX_SIDE = teot_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_command,
  input  wire logic [teot_pkg::PIX_W-1:0]            in_pixel_index,
  input  wire logic [teot_pkg::ALPHA_W-1:0]          in_pixel_alpha,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_a_x,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_a_y,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_b_x,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_b_y,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_c_x,
  input  wire logic signed [teot_pkg::VTX_W-1:0]     in_vertex_c_y,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_keep_triangle,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [teot_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [teot_pkg::CFG_W-1:0]            cfg_data
);

  localparam int STORE_SIZE = MAX_SIDE * MAX_SIDE;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int DELTA_W    = teot_pkg::DELTA_W;
  localparam int DIM_W      = teot_pkg::DIM_W;
  localparam int COORD_W    = teot_pkg::COORD_W;
  localparam int PROD_W     = teot_pkg::PROD_W;
  localparam int VTX_W      = teot_pkg::VTX_W;
  localparam int ALPHA_W    = teot_pkg::ALPHA_W;
  localparam int CFG_W      = teot_pkg::CFG_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DELTA = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Configuration registers
  logic [ALPHA_W-1:0] thr_r;
  logic [CFG_W-1:0]   img_w_r;
  logic [CFG_W-1:0]   img_h_r;

  // Sequencer state
  logic [2:0] state_r, state_nxt;
  logic [1:0] edge_r;
  logic [1:0] drain_r;

  // Triangle and image size for the current test
  logic signed [VTX_W-1:0] vax_r, vay_r, vbx_r, vby_r, vcx_r, vcy_r;
  logic [DIM_W-1:0] w_r, h_r;

  // Edge setup
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic signed [COORD_W-1:0] base_x_r, base_y_r;

  // Walk registers
  logic [DELTA_W-1:0]        n_r, rem_r, maj_len_r, min_len_r;
  logic                      maj_neg_r, min_neg_r, xmaj_r;
  logic signed [COORD_W-1:0] cur_maj_r, cur_min_r;

  // Sample pipeline
  logic                 s1_valid_r, s2_valid_r;
  logic [DIM_W-1:0]     s1_x_r;
  logic [PROD_W-1:0]    s1_prod_r;
  logic [ALPHA_W-1:0]   rd_data_r;
  logic                 hit_r;

  logic                 out_valid_r, out_keep_r;

  logic [ALPHA_W-1:0]   alpha_mem [STORE_SIZE];

  logic in_beat, test_beat, pix_wr;
  logic [AW-1:0] wr_addr, rd_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign test_beat = in_beat && (in_command == teot_pkg::CMD_TEST);
  assign pix_wr    = in_beat && (in_command == teot_pkg::CMD_WRITE)
                     && (32'(in_pixel_index) < STORE_SIZE);
  assign wr_addr   = AW'(in_pixel_index);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      img_w_r <= CFG_W'(256);
      img_h_r <= CFG_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        teot_pkg::REG_ALPHA_THRESHOLD: thr_r   <= cfg_data[ALPHA_W-1:0];
        teot_pkg::REG_IMAGE_WIDTH:     img_w_r <= cfg_data;
        teot_pkg::REG_IMAGE_HEIGHT:    img_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select edge endpoints
  logic signed [VTX_W-1:0] p1x, p1y, p2x, p2y;
  always_comb begin
    case (edge_r)
      teot_pkg::EDGE_AB: begin
        p1x = vax_r; p1y = vay_r; p2x = vbx_r; p2y = vby_r;
      end
      teot_pkg::EDGE_BC: begin
        p1x = vbx_r; p1y = vby_r; p2x = vcx_r; p2y = vcy_r;
      end
      teot_pkg::EDGE_CA: begin
        p1x = vcx_r; p1y = vcy_r; p2x = vax_r; p2y = vay_r;
      end
      default: begin
        p1x = vax_r; p1y = vay_r; p2x = vbx_r; p2y = vby_r;
      end
    endcase
  end

  // Deltas and start point relative to the image corner
  logic signed [DELTA_W-1:0] dx_calc, dy_calc;
  logic signed [COORD_W-1:0] bx_calc, by_calc;
  assign dx_calc = DELTA_W'(p2x) - DELTA_W'(p1x);
  assign dy_calc = DELTA_W'(p2y) - DELTA_W'(p1y);
  assign bx_calc = COORD_W'(p1x) + $signed(COORD_W'(w_r >> 1));
  assign by_calc = COORD_W'(p1y) + $signed(COORD_W'(h_r >> 1));

  // Pick major axis
  logic [DELTA_W-1:0] adx, ady, maj_len_calc, min_len_calc;
  logic               xmaj_calc;
  assign adx          = dx_r[DELTA_W-1] ? DELTA_W'(-dx_r) : DELTA_W'(dx_r);
  assign ady          = dy_r[DELTA_W-1] ? DELTA_W'(-dy_r) : DELTA_W'(dy_r);
  assign xmaj_calc    = adx > ady;
  assign maj_len_calc = xmaj_calc ? adx : ady;
  assign min_len_calc = xmaj_calc ? ady : adx;

  // Shared step unit: remainder add, compare and fold back
  logic [DELTA_W:0]   rem_sum;
  logic               minor_carry;
  logic [DELTA_W-1:0] rem_next;
  logic               last_step;
  assign rem_sum     = {1'b0, rem_r} + {1'b0, min_len_r};
  assign minor_carry = rem_sum >= {1'b0, maj_len_r};
  assign rem_next    = minor_carry ? DELTA_W'(rem_sum - {1'b0, maj_len_r})
                                   : DELTA_W'(rem_sum);
  assign last_step   = (n_r + DELTA_W'(1)) == maj_len_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (test_beat) state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_PREP;
      ST_PREP: begin
        if (maj_len_calc != '0) state_nxt = ST_WALK;
        else if (edge_r == teot_pkg::EDGE_CA) state_nxt = ST_DRAIN;
        else state_nxt = ST_DELTA;
      end
      ST_WALK: begin
        if (last_step) begin
          state_nxt = (edge_r == teot_pkg::EDGE_CA) ? ST_DRAIN : ST_DELTA;
        end
      end
      ST_DRAIN: if (drain_r == 2'd2) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      edge_r  <= teot_pkg::EDGE_AB;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (test_beat) begin
        edge_r <= teot_pkg::EDGE_AB;
      end else if ((state_r == ST_PREP && maj_len_calc == '0)
                   || (state_r == ST_WALK && last_step)) begin
        edge_r <= edge_r + 2'd1;
      end
      if (state_r == ST_DRAIN) drain_r <= drain_r + 2'd1;
      else drain_r <= '0;
    end
  end

  // Capture the test item and saturated image size
  always_ff @(posedge clk) begin
    if (test_beat) begin
      vax_r <= in_vertex_a_x;
      vay_r <= in_vertex_a_y;
      vbx_r <= in_vertex_b_x;
      vby_r <= in_vertex_b_y;
      vcx_r <= in_vertex_c_x;
      vcy_r <= in_vertex_c_y;
      w_r   <= (32'(img_w_r) > MAX_SIDE) ? DIM_W'(MAX_SIDE) : DIM_W'(img_w_r);
      h_r   <= (32'(img_h_r) > MAX_SIDE) ? DIM_W'(MAX_SIDE) : DIM_W'(img_h_r);
    end
  end

  // Edge setup and walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_DELTA: begin
        dx_r     <= dx_calc;
        dy_r     <= dy_calc;
        base_x_r <= bx_calc;
        base_y_r <= by_calc;
      end
      ST_PREP: begin
        xmaj_r    <= xmaj_calc;
        maj_len_r <= maj_len_calc;
        min_len_r <= min_len_calc;
        maj_neg_r <= xmaj_calc ? dx_r[DELTA_W-1] : dy_r[DELTA_W-1];
        min_neg_r <= xmaj_calc ? dy_r[DELTA_W-1] : dx_r[DELTA_W-1];
        cur_maj_r <= xmaj_calc ? base_x_r : base_y_r;
        cur_min_r <= xmaj_calc ? base_y_r : base_x_r;
        n_r       <= '0;
        rem_r     <= '0;
      end
      ST_WALK: begin
        n_r       <= n_r + DELTA_W'(1);
        rem_r     <= rem_next;
        cur_maj_r <= cur_maj_r + (maj_neg_r ? {COORD_W{1'b1}} : COORD_W'(1));
        if (minor_carry) begin
          cur_min_r <= cur_min_r + (min_neg_r ? {COORD_W{1'b1}} : COORD_W'(1));
        end
      end
      default: ;
    endcase
  end

  // Current sample point and image bounds check
  logic signed [COORD_W-1:0] samp_x, samp_y;
  logic                      samp_in;
  assign samp_x  = xmaj_r ? cur_maj_r : cur_min_r;
  assign samp_y  = xmaj_r ? cur_min_r : cur_maj_r;
  assign samp_in = !samp_x[COORD_W-1] && (COORD_W'(samp_x) < COORD_W'(w_r))
                   && !samp_y[COORD_W-1] && (COORD_W'(samp_y) < COORD_W'(h_r));

  // Sample pipeline: row offset, address and store read, threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == ST_WALK) && samp_in;
      s2_valid_r <= s1_valid_r;
      if (test_beat) hit_r <= 1'b0;
      else if (s2_valid_r && (rd_data_r > thr_r)) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r    <= samp_x[DIM_W-1:0];
    s1_prod_r <= PROD_W'(samp_y[DIM_W-1:0]) * PROD_W'(w_r);
  end

  assign rd_addr = AW'(PROD_W'(s1_x_r) + s1_prod_r);

  // Alpha store
  always_ff @(posedge clk) begin
    if (pix_wr) alpha_mem[wr_addr] <= in_pixel_alpha;
    rd_data_r <= alpha_mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) out_keep_r <= hit_r;
  end

  assign out_valid         = out_valid_r;
  assign out_keep_triangle = out_keep_r;

endmodule

`default_nettype wire

// File: design/teot_checker.sv
`default_nettype none

`include "triangle_edge_opacity_test_top_macros.svh"

module teot_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_command,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_keep_triangle
);

  // Hold a stalled result beat
  `TEOT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `TEOT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_keep_triangle))

  // Reset leaves the block ready with no result pending
  `TEOT_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !in_stall && !out_valid)

  // A pixel write never makes the block busy; a test always does
  `TEOT_ASSERT_NEXT(a_write_ready, clk, rst_n,
    in_valid && !in_stall && (in_command == teot_pkg::CMD_WRITE), !in_stall)
  `TEOT_ASSERT_NEXT(a_test_busy, clk, rst_n,
    in_valid && !in_stall && (in_command == teot_pkg::CMD_TEST), in_stall)

endmodule

bind triangle_edge_opacity_test_top teot_checker u_teot_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_keep_triangle (out_keep_triangle)
);

`default_nettype wire
